### hw/rtl/mlp_pkg.sv
// Shared constants and types for the two-layer perceptron inference block.
`default_nettype none

package mlp_pkg;

    localparam int SLOT_W       = 16;
    localparam int HID_REG_W    = 48;
    localparam int OUT_LOW_W    = 64;
    localparam int NUM_HID_REGS = 4;
    localparam int NUM_IN_FIELDS = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    typedef logic signed [SLOT_W-1:0] t_slot;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_HIDDEN0  = 3'd0;
    localparam t_cfg_idx CFG_HIDDEN1  = 3'd1;
    localparam t_cfg_idx CFG_HIDDEN2  = 3'd2;
    localparam t_cfg_idx CFG_HIDDEN3  = 3'd3;
    localparam t_cfg_idx CFG_OUT_LOW  = 3'd4;
    localparam t_cfg_idx CFG_OUT_LAST = 3'd5;

endpackage

`default_nettype wire

### hw/rtl/mlp_mac_cell.sv
// Multiply-accumulate cell: adds one weighted term and hands the sum and operands on.
`default_nettype none

module mlp_mac_cell #(
    parameter int ACC_W  = 24,
    parameter int DATA_W = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [ACC_W-1:0]      i_acc,
    input  wire logic [DATA_W-1:0]     i_data,
    input  wire mlp_pkg::t_slot        i_operand,
    input  wire mlp_pkg::t_slot        i_weight,
    output logic                       o_valid,
    output logic [ACC_W-1:0]           o_acc,
    output logic [DATA_W-1:0]          o_data
);
    import mlp_pkg::*;

    logic                       r_valid;
    logic [ACC_W-1:0]           r_acc;
    logic [DATA_W-1:0]          r_data;
    logic signed [2*SLOT_W-1:0] prod;
    logic [ACC_W-1:0]           n_acc;

    // sum is kept modulo 2^ACC_W: only the bits above the fraction survive narrowing
    assign prod  = i_operand * i_weight;
    assign n_acc = i_acc + prod[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc  <= n_acc;
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### hw/rtl/mlp_two_layer_relu_inference_top.sv
// Top level: config registers, input skid, hidden and output MAC chains, output register.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+-----------------------------------
//  sample   | i_valid   | o_stall   | i_feature_first, i_feature_second
//  result   | o_valid   | i_stall   | o_prediction
//  config   | i_cfg_we  | -         | i_cfg_index, i_cfg_data
//
// One sample per cycle sustained while the result side does not stall. Each sample
// passes one registered cell per product term in each chain, then the output register.
// Reset clears valids and config registers. A result-side stall with o_valid high
// freezes the whole chain; the input skid register takes one more transfer, then o_stall.
`default_nettype none

module mlp_two_layer_relu_inference_top #(
    parameter int NUM_FEATURES = 2,
    parameter int NUM_HIDDEN   = 4,
    parameter int FRAC_BITS    = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire mlp_pkg::t_slot             i_feature_first,
    input  wire mlp_pkg::t_slot             i_feature_second,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output mlp_pkg::t_slot                  o_prediction,
    input  wire logic                       i_cfg_we,
    input  wire mlp_pkg::t_cfg_idx          i_cfg_index,
    input  wire logic [mlp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mlp_pkg::*;

    localparam int ACC_W   = FRAC_BITS + SLOT_W;
    localparam int FEAT_W  = NUM_IN_FIELDS * SLOT_W;
    localparam int ACT_W   = NUM_HIDDEN * SLOT_W;

    // configuration
    logic [HID_REG_W-1:0] r_hid_w [NUM_HID_REGS];
    logic [OUT_LOW_W-1:0] r_out_low;
    t_slot                r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_HID_REGS; k++) begin
                r_hid_w[k] <= '0;
            end
            r_out_low  <= '0;
            r_out_last <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HIDDEN0:  r_hid_w[0] <= i_cfg_data[HID_REG_W-1:0];
                CFG_HIDDEN1:  r_hid_w[1] <= i_cfg_data[HID_REG_W-1:0];
                CFG_HIDDEN2:  r_hid_w[2] <= i_cfg_data[HID_REG_W-1:0];
                CFG_HIDDEN3:  r_hid_w[3] <= i_cfg_data[HID_REG_W-1:0];
                CFG_OUT_LOW:  r_out_low  <= i_cfg_data[OUT_LOW_W-1:0];
                CFG_OUT_LAST: r_out_last <= i_cfg_data[SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control
    logic              en;
    logic              r_skid_valid;
    logic [FEAT_W-1:0] r_skid_data;
    logic              src_valid;
    logic [FEAT_W-1:0] src_data;
    logic              r_out_valid;
    t_slot             r_pred;

    assign en        = !r_out_valid || !i_stall;
    assign src_valid = r_skid_valid || i_valid;
    assign src_data  = r_skid_valid ? r_skid_data : {i_feature_second, i_feature_first};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else begin
            r_skid_valid <= !en && (r_skid_valid || i_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && !r_skid_valid) begin
            r_skid_data <= {i_feature_second, i_feature_first};
        end
    end

    assign o_stall = r_skid_valid;

    // hidden layer: one lane per neuron, one cell per feature
    logic              hid_vld  [NUM_HIDDEN][NUM_FEATURES+1];
    logic [ACC_W-1:0]  hid_acc  [NUM_HIDDEN][NUM_FEATURES+1];
    logic [FEAT_W-1:0] hid_data [NUM_HIDDEN][NUM_FEATURES+1];
    logic [ACT_W-1:0]  act_vec;

    for (genvar h = 0; h < NUM_HIDDEN; h++) begin : g_hid
        assign hid_vld[h][0]  = src_valid;
        assign hid_data[h][0] = src_data;
        assign hid_acc[h][0]  = ACC_W'($unsigned(r_hid_w[h][SLOT_W-1:0])) << FRAC_BITS;

        for (genvar f = 0; f < NUM_FEATURES; f++) begin : g_cell
            t_slot operand;
            t_slot weight;
            if (f < NUM_IN_FIELDS) begin : g_feat
                assign operand = hid_data[h][f][f*SLOT_W +: SLOT_W];
                assign weight  = r_hid_w[h][(f+1)*SLOT_W +: SLOT_W];
            end else begin : g_zero
                assign operand = '0;
                assign weight  = '0;
            end

            mlp_mac_cell #(
                .ACC_W  (ACC_W),
                .DATA_W (FEAT_W)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_en      (en),
                .i_valid   (hid_vld[h][f]),
                .i_acc     (hid_acc[h][f]),
                .i_data    (hid_data[h][f]),
                .i_operand (operand),
                .i_weight  (weight),
                .o_valid   (hid_vld[h][f+1]),
                .o_acc     (hid_acc[h][f+1]),
                .o_data    (hid_data[h][f+1])
            );
        end

        t_slot narrowed;
        assign narrowed = hid_acc[h][NUM_FEATURES][ACC_W-1 -: SLOT_W];
        assign act_vec[h*SLOT_W +: SLOT_W] = narrowed[SLOT_W-1] ? '0 : narrowed;
    end

    // output neuron: one cell per hidden activation
    logic             out_vld  [NUM_HIDDEN+1];
    logic [ACC_W-1:0] out_acc  [NUM_HIDDEN+1];
    logic [ACT_W-1:0] out_data [NUM_HIDDEN+1];

    assign out_vld[0]  = hid_vld[0][NUM_FEATURES];
    assign out_data[0] = act_vec;
    assign out_acc[0]  = ACC_W'($unsigned(r_out_low[SLOT_W-1:0])) << FRAC_BITS;

    for (genvar h = 0; h < NUM_HIDDEN; h++) begin : g_out
        t_slot weight;
        if (h < 3) begin : g_low
            assign weight = r_out_low[(h+1)*SLOT_W +: SLOT_W];
        end else begin : g_last
            assign weight = r_out_last;
        end

        mlp_mac_cell #(
            .ACC_W  (ACC_W),
            .DATA_W (ACT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_valid   (out_vld[h]),
            .i_acc     (out_acc[h]),
            .i_data    (out_data[h]),
            .i_operand (out_data[h][h*SLOT_W +: SLOT_W]),
            .i_weight  (weight),
            .o_valid   (out_vld[h+1]),
            .o_acc     (out_acc[h+1]),
            .o_data    (out_data[h+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= out_vld[NUM_HIDDEN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pred <= out_acc[NUM_HIDDEN][ACC_W-1 -: SLOT_W];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_prediction = r_pred;

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the two-layer ReLU perceptron inference block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mlp_pkg::*;

    localparam int       FRAC_BITS         = 8;
    localparam int       LATENCY           = 7;
    localparam int       HOLD_CYCLES       = 80;
    localparam int       NUM_PHASES        = 10;
    localparam int       SAMPLES_PER_PHASE = 163;
    localparam int       MAX_REPORTS       = 20;
    localparam t_cfg_idx CFG_SPARE6        = 3'd6;
    localparam t_cfg_idx CFG_SPARE7        = 3'd7;

    class prediction_board;
        t_slot hid_w[NUM_HID_REGS][3];
        t_slot out_w[5];
        t_slot expected_q[$];
        int    mismatches;
        int    samples;
        int    predictions;

        function new();
            for (int h = 0; h < NUM_HID_REGS; h++) begin
                for (int k = 0; k < 3; k++) hid_w[h][k] = '0;
            end
            for (int k = 0; k < 5; k++) out_w[k] = '0;
            mismatches  = 0;
            samples     = 0;
            predictions = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            if (idx <= CFG_HIDDEN3) begin
                for (int k = 0; k < 3; k++) hid_w[idx][k] = data[16*k +: 16];
            end else if (idx == CFG_OUT_LOW) begin
                for (int k = 0; k < 4; k++) out_w[k] = data[16*k +: 16];
            end else if (idx == CFG_OUT_LAST) begin
                out_w[4] = data[15:0];
            end
        endfunction

        // floor shift, then wrap to 16 bits
        function t_slot narrow(longint acc);
            longint shifted;
            shifted = acc >>> FRAC_BITS;
            return t_slot'(shifted[15:0]);
        endfunction

        function void note_sample(t_slot f0, t_slot f1);
            t_slot  act[NUM_HID_REGS];
            longint acc;
            for (int h = 0; h < NUM_HID_REGS; h++) begin
                acc = longint'(hid_w[h][0]) <<< FRAC_BITS;
                acc += longint'(hid_w[h][1]) * longint'(f0);
                acc += longint'(hid_w[h][2]) * longint'(f1);
                act[h] = narrow(acc);
                if (act[h] < 0) act[h] = '0;
            end
            acc = longint'(out_w[0]) <<< FRAC_BITS;
            for (int h = 0; h < NUM_HID_REGS; h++) begin
                acc += longint'(out_w[h+1]) * longint'(act[h]);
            end
            expected_q.push_back(narrow(acc));
            samples++;
        endfunction

        function void check_result(t_slot got);
            t_slot want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("prediction: unexpected transfer %0d, nothing outstanding", got);
                return;
            end
            want = expected_q.pop_front();
            predictions++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("prediction mismatch: expected %0d, actual %0d", want, got);
            end
        endfunction
    endclass

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_valid          = 1'b0;
    logic                  o_stall;
    t_slot                 i_feature_first  = '0;
    t_slot                 i_feature_second = '0;
    logic                  o_valid;
    logic                  i_stall          = 1'b0;
    t_slot                 o_prediction;
    logic                  i_cfg_we         = 1'b0;
    t_cfg_idx              i_cfg_index      = CFG_HIDDEN0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    prediction_board board = new();

    int    gap_pct      = 0;
    int    stall_pct    = 0;
    bit    hold_request = 1'b0;
    t_slot cfg_hid[NUM_HID_REGS][3];
    t_slot cfg_out[5];

    mlp_two_layer_relu_inference_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_feature_first  (i_feature_first),
        .i_feature_second (i_feature_second),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_prediction     (o_prediction),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_len();
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 4);
    endfunction

    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        return pick_len();
    endfunction

    function automatic t_slot pick_feature();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return t_slot'(int'($urandom_range(0, 1024)) - 512);
            default: return t_slot'($urandom);
        endcase
    endfunction

    function automatic t_slot pick_weight(bit modest);
        if (modest) return t_slot'(int'($urandom_range(0, 768)) - 384);
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'h0100;
            4:       return 16'hFF00;
            5:       return t_slot'(int'($urandom_range(0, 1024)) - 512);
            default: return t_slot'($urandom);
        endcase
    endfunction

    // result side: random stall runs, plus one long hold-off on request
    initial begin
        int   run_left;
        logic stall_now;
        run_left  = 0;
        stall_now = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                run_left = 0;
            end else begin
                if (run_left == 0) begin
                    stall_now = ($urandom_range(0, 99) < stall_pct);
                    run_left  = pick_len();
                end
                i_stall <= stall_now;
                run_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check_result(o_prediction);
    end

    task automatic drive_sample(t_slot f0, t_slot f1, int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid          <= 1'b1;
        i_feature_first  <= f0;
        i_feature_second <= f1;
        do @(posedge i_clk); while (o_stall);
        board.note_sample(f0, f1);
    endtask

    task automatic end_phase();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // upper bits beyond each register narrower than the data word are filled with junk
    task automatic program_weights();
        for (int h = 0; h < NUM_HID_REGS; h++) begin
            write_reg(t_cfg_idx'(CFG_HIDDEN0 + h),
                      {16'($urandom), cfg_hid[h][2], cfg_hid[h][1], cfg_hid[h][0]});
        end
        write_reg(CFG_OUT_LOW, {cfg_out[3], cfg_out[2], cfg_out[1], cfg_out[0]});
        write_reg(CFG_OUT_LAST, {$urandom, 16'($urandom), cfg_out[4]});
        write_reg(CFG_SPARE6, {$urandom, $urandom});
        write_reg(CFG_SPARE7, {$urandom, $urandom});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic fill_weights(int phase);
        for (int h = 0; h < NUM_HID_REGS; h++) begin
            for (int k = 0; k < 3; k++) begin
                case (phase)
                    0:       cfg_hid[h][k] = 16'h7FFF;
                    1:       cfg_hid[h][k] = 16'h8000;
                    2:       cfg_hid[h][k] = 16'hFFFF;
                    default: cfg_hid[h][k] = pick_weight(phase % 3 == 0);
                endcase
            end
        end
        for (int k = 0; k < 5; k++) begin
            case (phase)
                0:       cfg_out[k] = 16'h7FFF;
                1:       cfg_out[k] = 16'h8000;
                2:       cfg_out[k] = 16'hFFFF;
                default: cfg_out[k] = pick_weight(phase % 3 == 0);
            endcase
        end
    endtask

    initial begin
        t_slot dir_f0[13];
        t_slot dir_f1[13];
        dir_f0 = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0100, 16'hFF00,
                   16'h0001, 16'hFFFF, 16'h0080, 16'h1234, 16'h4000, 16'hC000};
        dir_f1 = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0100, 16'h0100,
                   16'hFFFF, 16'hFFFF, 16'hFF80, 16'hEDCB, 16'h4000, 16'h3FFF};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // weights straight out of reset: every prediction is zero
        gap_pct   = 20;
        stall_pct = 20;
        for (int i = 0; i < 3; i++) drive_sample(dir_f0[i+1], dir_f1[i+1], pick_gap(gap_pct));
        end_phase();

        // identity, negative, overflowing and most-negative neurons
        cfg_hid[0] = '{16'h0000, 16'h0100, 16'h0100};
        cfg_hid[1] = '{16'hFF00, 16'hFF00, 16'h0000};
        cfg_hid[2] = '{16'h7FFF, 16'h7FFF, 16'h7FFF};
        cfg_hid[3] = '{16'h8000, 16'h8000, 16'h8000};
        cfg_out    = '{16'h0080, 16'h0100, 16'h0100, 16'hFF00, 16'h7FFF};
        program_weights();
        for (int i = 0; i < 13; i++) drive_sample(dir_f0[i], dir_f1[i], pick_gap(gap_pct));
        end_phase();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            fill_weights(phase);
            program_weights();
            case (phase)
                3: begin
                    gap_pct      = 0;
                    stall_pct    = 10;
                    hold_request = 1'b1;
                end
                4: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                default: begin
                    gap_pct   = 10 + 25 * $urandom_range(0, 2);
                    stall_pct = 10 + 25 * $urandom_range(0, 2);
                end
            endcase
            for (int i = 0; i < SAMPLES_PER_PHASE; i++)
                drive_sample(pick_feature(), pick_feature(), pick_gap(gap_pct));
            end_phase();
        end

        repeat (4 * LATENCY) @(posedge i_clk);
        $display("Ran %0d samples over %0d weight settings, extremes and a long hold-off included.",
                 board.samples, NUM_PHASES + 2);
        $display("%0d predictions checked, %0d mismatches.", board.predictions, board.mismatches);
        if (board.mismatches == 0 && board.expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
